FILE: hdl/gag_pkg.sv
`default_nettype none

package gag_pkg;

    localparam int unsigned POS_W   = 10;
    localparam int unsigned CUR_W   = 10;
    localparam int unsigned DRV_W   = 10;
    localparam int unsigned DZ_W    = 9;
    localparam int unsigned STUCK_W = 16;
    localparam int unsigned OC_W    = 8;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POS_MIDDLE      = 3'd0,
        CFG_DEAD_ZONE       = 3'd1,
        CFG_POS_UPPER_LIMIT = 3'd2,
        CFG_POS_LOWER_LIMIT = 3'd3,
        CFG_STUCK_TIMEOUT   = 3'd4,
        CFG_FORCE_LIMIT     = 3'd5,
        CFG_FORCE_CRITICAL  = 3'd6,
        CFG_FORCE_TIMEOUT   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_CW   = 2'd1,
        CMD_CCW  = 2'd2,
        CMD_STOP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_UPPER = 2'd1,
        SIDE_LOWER = 2'd2
    } t_side;

    typedef enum logic [1:0] {
        RET_IDLE  = 2'd0,
        RET_UPPER = 2'd1,
        RET_LOWER = 2'd2
    } t_ret;

    typedef enum logic [1:0] {
        SHIFT_NONE = 2'd0,
        SHIFT_UP   = 2'd1,
        SHIFT_DOWN = 2'd2
    } t_shift;

    typedef enum logic {
        REQ_TICK   = 1'b0,
        REQ_SWITCH = 1'b1
    } t_req;

    localparam logic [POS_W-1:0]   RST_POS_MIDDLE      = 10'd512;
    localparam logic [DZ_W-1:0]    RST_DEAD_ZONE       = 9'd32;
    localparam logic [POS_W-1:0]   RST_POS_UPPER_LIMIT = 10'd900;
    localparam logic [POS_W-1:0]   RST_POS_LOWER_LIMIT = 10'd124;
    localparam logic [STUCK_W-1:0] RST_STUCK_TIMEOUT   = 16'd100;
    localparam logic [CUR_W-1:0]   RST_FORCE_LIMIT     = 10'd800;
    localparam logic [CUR_W-1:0]   RST_FORCE_CRITICAL  = 10'd900;
    localparam logic [OC_W-1:0]    RST_FORCE_TIMEOUT   = 8'd70;

    typedef struct packed {
        logic [POS_W-1:0]   pos_middle;
        logic [DZ_W-1:0]    dead_zone;
        logic [POS_W-1:0]   pos_upper_limit;
        logic [POS_W-1:0]   pos_lower_limit;
        logic [STUCK_W-1:0] stuck_timeout;
        logic [CUR_W-1:0]   force_limit;
        logic [CUR_W-1:0]   force_critical;
        logic [OC_W-1:0]    force_timeout;
    } t_cfg;

    typedef struct packed {
        t_req              req_type;
        logic [POS_W-1:0]  arm_pos;
        logic [CUR_W-1:0]  motor_current;
        logic              current_fresh;
        logic [DRV_W-1:0]  drive_in;
        logic [1:0]        shift_dir;
    } t_in_item;

    typedef struct packed {
        t_cmd             motor_cmd;
        logic [DRV_W-1:0] drive_out;
        t_side            side_off;
        logic             bridge_enable;
        t_ret             return_state;
        logic [OC_W-1:0]  overcurrent_level;
    } t_out_item;

endpackage

`default_nettype wire

FILE: hdl/gag_cfg_regs.sv
`default_nettype none

module gag_cfg_regs import gag_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_middle      <= RST_POS_MIDDLE;
            r_cfg.dead_zone       <= RST_DEAD_ZONE;
            r_cfg.pos_upper_limit <= RST_POS_UPPER_LIMIT;
            r_cfg.pos_lower_limit <= RST_POS_LOWER_LIMIT;
            r_cfg.stuck_timeout   <= RST_STUCK_TIMEOUT;
            r_cfg.force_limit     <= RST_FORCE_LIMIT;
            r_cfg.force_critical  <= RST_FORCE_CRITICAL;
            r_cfg.force_timeout   <= RST_FORCE_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_POS_MIDDLE:      r_cfg.pos_middle      <= i_cfg_wdata[POS_W-1:0];
                CFG_DEAD_ZONE:       r_cfg.dead_zone       <= i_cfg_wdata[DZ_W-1:0];
                CFG_POS_UPPER_LIMIT: r_cfg.pos_upper_limit <= i_cfg_wdata[POS_W-1:0];
                CFG_POS_LOWER_LIMIT: r_cfg.pos_lower_limit <= i_cfg_wdata[POS_W-1:0];
                CFG_STUCK_TIMEOUT:   r_cfg.stuck_timeout   <= i_cfg_wdata[STUCK_W-1:0];
                CFG_FORCE_LIMIT:     r_cfg.force_limit     <= i_cfg_wdata[CUR_W-1:0];
                CFG_FORCE_CRITICAL:  r_cfg.force_critical  <= i_cfg_wdata[CUR_W-1:0];
                CFG_FORCE_TIMEOUT:   r_cfg.force_timeout   <= i_cfg_wdata[OC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/gag_core.sv
`default_nettype none

module gag_core import gag_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_step,
    input  t_in_item  i_item,
    output t_out_item o_res
);

    logic [STUCK_W-1:0] r_stuck, n_stuck;
    logic [OC_W-1:0]    r_oc, n_oc;
    logic               r_ret_upper, n_ret_upper;
    logic               r_ret_lower, n_ret_lower;
    logic [DRV_W-1:0]   r_drv, n_drv;
    t_shift             r_pend, n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stuck     <= '0;
            r_oc        <= '0;
            r_ret_upper <= 1'b0;
            r_ret_lower <= 1'b0;
            r_drv       <= '0;
            r_pend      <= SHIFT_NONE;
        end else if (i_step) begin
            r_stuck     <= n_stuck;
            r_oc        <= n_oc;
            r_ret_upper <= n_ret_upper;
            r_ret_lower <= n_ret_lower;
            r_drv       <= n_drv;
            r_pend      <= n_pend;
        end
    end

    always_comb begin
        logic [POS_W:0]  band_hi;
        logic [POS_W:0]  pos_dz;
        logic            above;
        logic            below;
        logic            timed_out;
        logic [OC_W:0]   oc_inc;
        logic [OC_W-1:0] oc_low;
        t_cmd            cmd;
        t_side           side;

        n_stuck     = r_stuck;
        n_oc        = r_oc;
        n_ret_upper = r_ret_upper;
        n_ret_lower = r_ret_lower;
        n_drv       = r_drv;
        n_pend      = r_pend;
        cmd         = CMD_NONE;
        side        = SIDE_NONE;

        // band bounds compared without going signed: pos < mid - dz <=> pos + dz < mid
        band_hi = {1'b0, i_cfg.pos_middle} + {2'b00, i_cfg.dead_zone};
        pos_dz  = {1'b0, i_item.arm_pos} + {2'b00, i_cfg.dead_zone};
        above   = {1'b0, i_item.arm_pos} > band_hi;
        below   = pos_dz < {1'b0, i_cfg.pos_middle};
        oc_inc  = {1'b0, r_oc} + {{OC_W{1'b0}}, 1'b1};
        oc_low  = r_oc;
        timed_out = 1'b0;

        if (i_item.req_type == REQ_TICK) begin
            if (above || below) begin
                if (r_stuck != {STUCK_W{1'b1}}) begin
                    n_stuck = r_stuck + {{(STUCK_W-1){1'b0}}, 1'b1};
                end
            end else begin
                n_stuck = '0;
            end
            timed_out = n_stuck > i_cfg.stuck_timeout;
            if (timed_out && above) begin
                n_ret_lower = 1'b0;
                n_ret_upper = 1'b1;
            end
            if (timed_out && below) begin
                n_ret_lower = 1'b1;
                n_ret_upper = 1'b0;
            end

            if (i_item.motor_current > i_cfg.force_limit) begin
                if (oc_inc > {1'b0, i_cfg.force_timeout}) begin
                    n_oc = i_cfg.force_timeout;
                end else begin
                    n_oc = oc_inc[OC_W-1:0];
                end
            end else begin
                // critical branch only reachable with critical below limit;
                // the low-current decrement still follows
                if (i_item.motor_current > i_cfg.force_critical) begin
                    oc_low = i_cfg.force_timeout;
                end
                if (oc_low != '0) begin
                    n_oc = oc_low - {{(OC_W-1){1'b0}}, 1'b1};
                end else begin
                    n_oc = '0;
                end
            end

            if (i_item.current_fresh) begin
                n_drv = i_item.drive_in;
            end

            if (n_ret_upper) begin
                if (above) begin
                    cmd = CMD_CCW;
                end else begin
                    cmd = CMD_STOP;
                    n_ret_upper = 1'b0;
                    n_ret_lower = 1'b0;
                end
            end
            if (n_ret_lower) begin
                if (below) begin
                    cmd = CMD_CW;
                end else begin
                    cmd = CMD_STOP;
                    n_ret_upper = 1'b0;
                    n_ret_lower = 1'b0;
                end
            end

            if (!n_ret_upper && !n_ret_lower) begin
                if (i_item.arm_pos > i_cfg.pos_upper_limit) begin
                    side        = SIDE_UPPER;
                    n_ret_upper = 1'b1;
                end else if (i_item.arm_pos < i_cfg.pos_lower_limit) begin
                    side        = SIDE_LOWER;
                    n_ret_lower = 1'b1;
                end
            end
        end else begin
            if (i_item.shift_dir == SHIFT_UP || i_item.shift_dir == SHIFT_DOWN) begin
                n_pend = t_shift'(i_item.shift_dir);
            end
            if (!r_ret_upper && !r_ret_lower) begin
                if (n_pend == SHIFT_UP) begin
                    n_pend = SHIFT_NONE;
                    cmd    = CMD_CW;
                end else if (n_pend == SHIFT_DOWN) begin
                    n_pend = SHIFT_NONE;
                    cmd    = CMD_CCW;
                end
            end
        end

        o_res.motor_cmd         = cmd;
        o_res.drive_out         = (cmd == CMD_CW || cmd == CMD_CCW) ? n_drv : '0;
        o_res.side_off          = side;
        o_res.bridge_enable     = n_oc < {1'b0, i_cfg.force_timeout[OC_W-1:1]};
        o_res.return_state      = n_ret_upper ? RET_UPPER :
                                  (n_ret_lower ? RET_LOWER : RET_IDLE);
        o_res.overcurrent_level = n_oc;
    end

`ifndef SYNTHESIS
    a_ret_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ret_upper && r_ret_lower))
        else $error("return from both sides at once");

    a_pend_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == SHIFT_NONE || r_pend == SHIFT_UP || r_pend == SHIFT_DOWN)
        else $error("pending shift holds an unknown direction");

    a_side_starts_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.side_off != SIDE_NONE |=> r_ret_upper || r_ret_lower)
        else $error("side cut without a return in progress");

    a_switch_keeps_tick_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.req_type == REQ_SWITCH |=>
        $stable(r_stuck) && $stable(r_oc) && $stable(r_drv))
        else $error("switch event changed tick state");
`endif

endmodule

`default_nettype wire

FILE: hdl/gear_actuator_guard.sv
`default_nettype none

// Gear-shift actuator guard.
// Input stream (s_axis): one item per timer tick or shift switch event; tuser
// carries the request kind, tdata the arm position, motor current, fresh flag,
// drive level and shift direction. Output stream (m_axis): exactly one result
// item per input item, in order: motor command, drive level, side cut, bridge
// enable, return state and overcurrent count.
// Configuration: eight registers, written through i_cfg_we/i_cfg_addr/i_cfg_wdata
// only while the block is idle; the user must ensure this, the block does not.
// Timing: an item is held in the input register, evaluated against the guard
// state by combinational logic, and its result is registered in the output
// register; one item per cycle sustained while m_axis_tready stays high.
// Reset (synchronous, active low) empties both registers, clears the guard
// state and restores the register defaults.
// When m_axis_tready is low the result holds in the output register; one more
// item is taken into the input register, after which s_axis_tready drops
// until the result is taken.

module gear_actuator_guard import gag_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [9:0] arm_pos, [19:10] motor_current, [20] current_fresh,
    // [30:21] drive_in, [32:31] shift_dir, [39:33] zero
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [1:0] motor_cmd, [11:2] drive_out, [13:12] side_off, [14] bridge_enable,
    // [16:15] return_state, [24:17] overcurrent_level, [31:25] zero
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg      cfg;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item res;
    t_out_item r_out_item;
    logic      r_out_valid;
    logic      advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.req_type      <= t_req'(s_axis_tuser);
            r_in_item.arm_pos       <= s_axis_tdata[9:0];
            r_in_item.motor_current <= s_axis_tdata[19:10];
            r_in_item.current_fresh <= s_axis_tdata[20];
            r_in_item.drive_in      <= s_axis_tdata[30:21];
            r_in_item.shift_dir     <= s_axis_tdata[32:31];
        end
    end

    gag_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    gag_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (advance),
        .i_item  (r_in_item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0,
                            r_out_item.overcurrent_level,
                            r_out_item.return_state,
                            r_out_item.bridge_enable,
                            r_out_item.side_off,
                            r_out_item.drive_out,
                            r_out_item.motor_cmd};

endmodule

`default_nettype wire
